// ----- rtl/pctp_pkg.sv -----
// ----------------------------------------------------------------------------
// pctp_pkg: shared types and constants of the pulse count to power block
// Widths of the reading and result words, the per-sensor table entry and the
// control structs between the core, the table store and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package pctp_pkg;

  // table depth and address width
  localparam int SENSORS  = 16;
  localparam int SENSOR_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  // field widths of the channels
  localparam int SENSOR_IN_W  = 8;
  localparam int TIME_W       = 32;
  localparam int COUNT_W      = 32;
  localparam int RATE_W       = 16;
  localparam int SENSOR_OUT_W = 4;
  localparam int WATTS_W      = 14;

  // milliseconds per hour
  localparam int SCALE_W = 22;
  localparam logic [SCALE_W-1:0] MS_PER_HOUR = 22'd3600000;

  // datapath widths: numerator, denominator, quotient incl. overflow bit
  localparam int NUM_W  = COUNT_W + SCALE_W;
  localparam int DEN_W  = TIME_W + RATE_W;
  localparam int QUOT_W = WATTS_W + 1;
  localparam int DSH_W  = DEN_W + QUOT_W - 1;
  localparam int STEP_W = $clog2(QUOT_W);

  localparam logic [QUOT_W-1:0] MAX_WATTS = 15'd10000;

  // one row of the sensor table
  typedef struct packed {
    logic [TIME_W-1:0]  ts;
    logic [COUNT_W-1:0] cnt;
    logic [RATE_W-1:0]  rate;
  } entry_t;

  typedef struct packed {
    logic                en;
    logic [SENSOR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic                en;
    logic [SENSOR_W-1:0] addr;
    entry_t              data;
  } wr_req_t;

  // entry as seen by the core; a never-written row reads as zero
  typedef struct packed {
    logic   seen;
    entry_t data;
  } rd_rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               fit;
    logic [WATTS_W-1:0] watts;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } state_t;

  // absolute difference of two 32-bit words
  function automatic logic [TIME_W-1:0] abs_diff32(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
    abs_diff32 = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pctp_in_if.sv -----
// ----------------------------------------------------------------------------
// pctp_in_if: meter reading channel
// Valid/ready channel carrying one reading word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pctp_in_if;
  logic                             valid;
  logic                             ready;
  logic [pctp_pkg::SENSOR_IN_W-1:0] sensor;
  logic [pctp_pkg::TIME_W-1:0]      timestamp;
  logic [pctp_pkg::COUNT_W-1:0]     pulse_count;
  logic [pctp_pkg::RATE_W-1:0]      pulses_per_unit;

  modport source(output valid, sensor, timestamp, pulse_count, pulses_per_unit,
                 input ready);
  modport sink(input valid, sensor, timestamp, pulse_count, pulses_per_unit,
               output ready);
endinterface

`default_nettype wire

// ----- rtl/pctp_out_if.sv -----
// ----------------------------------------------------------------------------
// pctp_out_if: power result channel
// Valid/ready channel carrying one power word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pctp_out_if;
  logic                              valid;
  logic                              ready;
  logic [pctp_pkg::SENSOR_OUT_W-1:0] sensor_out;
  logic [pctp_pkg::TIME_W-1:0]       time_out;
  logic [pctp_pkg::WATTS_W-1:0]      power_watts;

  modport source(output valid, sensor_out, time_out, power_watts, input ready);
  modport sink(input valid, sensor_out, time_out, power_watts, output ready);
endinterface

`default_nettype wire

// ----- rtl/pctp_store.sv -----
// ----------------------------------------------------------------------------
// pctp_store: per-sensor table of last time, count and rate
// Synchronous memory with a registered read port and a write port, plus one
// seen flag per sensor in flip-flops that reset clears.
// ----------------------------------------------------------------------------
`default_nettype none

module pctp_store (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pctp_pkg::rd_req_t rd_req,
  input  wire pctp_pkg::wr_req_t wr_req,
  output pctp_pkg::rd_rsp_t      rd_rsp
);

  pctp_pkg::entry_t                 mem [pctp_pkg::SENSORS];
  logic [pctp_pkg::SENSORS-1:0]     seen_r;
  pctp_pkg::entry_t                 rd_data_r;
  logic                             rd_seen_r;

  // table memory: write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

  // seen flags double as valid bits of the table rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      rd_seen_r <= 1'b0;
    end else begin
      if (wr_req.en) begin
        seen_r[wr_req.addr] <= 1'b1;
      end
      if (rd_req.en) begin
        rd_seen_r <= seen_r[rd_req.addr];
      end
    end
  end

  // a row not yet written reads as all zero
  always_comb begin
    rd_rsp.seen = rd_seen_r;
    rd_rsp.data = rd_seen_r ? rd_data_r : '0;
  end

endmodule

`default_nettype wire

// ----- rtl/pctp_div.sv -----
// ----------------------------------------------------------------------------
// pctp_div: bit-serial restoring divider for the power quotient
// Produces one quotient bit per cycle once started and flags whether
// the exact quotient lies in 0..MAX_WATTS.
// ----------------------------------------------------------------------------
`default_nettype none

module pctp_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pctp_pkg::div_req_t req,
  output pctp_pkg::div_rsp_t      rsp
);

  logic [pctp_pkg::NUM_W-1:0]  rem_r;
  logic [pctp_pkg::DSH_W-1:0]  dsh_r;
  logic [pctp_pkg::QUOT_W-1:0] quot_r;
  logic [pctp_pkg::STEP_W-1:0] step_r;
  logic                        busy_r;
  logic                        done_r;
  logic                        take;

  // trial subtract of the shifted divisor
  assign take = pctp_pkg::DSH_W'(rem_r) >= dsh_r;

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // remainder, shifted divisor and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      dsh_r  <= {req.den, {(pctp_pkg::QUOT_W-1){1'b0}}};
      quot_r <= '0;
      step_r <= pctp_pkg::STEP_W'(pctp_pkg::QUOT_W - 1);
    end else if (busy_r) begin
      if (take) begin
        rem_r <= rem_r - dsh_r[pctp_pkg::NUM_W-1:0];
      end
      quot_r <= {quot_r[pctp_pkg::QUOT_W-2:0], take};
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

  // in range when below the limit, or exactly at it with no remainder
  always_comb begin
    rsp.done  = done_r;
    rsp.fit   = (quot_r < pctp_pkg::MAX_WATTS) ||
                ((quot_r == pctp_pkg::MAX_WATTS) && (rem_r == '0));
    rsp.watts = quot_r[pctp_pkg::WATTS_W-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/pulse_count_to_power_core.sv -----
// ----------------------------------------------------------------------------
// pulse_count_to_power_core: average power from pulse-meter readings
// Keeps the last reading of each sensor and turns the next one into watts.
// ----------------------------------------------------------------------------
// Each accepted reading is processed alone, in the states in order: ST_IDLE
// takes the word and reads the sensor's table row, ST_CALC forms the deltas
// and writes the row back, ST_MUL forms the two products, ST_CHECK checks the
// denominator and starts the bit-serial divider, ST_DIV waits to see it
// finish, and ST_OUT hands the result to the output register. A reading whose
// power is out of range returns to ST_IDLE from ST_DIV, the first reading of
// a sensor or one with a zero denominator returns from ST_CHECK, and a
// reading with an out-of-range index never leaves ST_IDLE. A result word that
// cannot enter the output register because the previous one is still stalled
// waits in ST_OUT until that one is taken. in_ch.ready is high only while no
// reading is in progress; a finished word waits in the output register
// without holding up the next reading. Readings for a sensor index at or
// above SENSORS are taken and dropped. The table is valid right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_count_to_power_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pctp_in_if.sink     in_ch,
  pctp_out_if.source  out_ch
);

  pctp_pkg::state_t   state_r, state_nxt;
  pctp_pkg::rd_req_t  rd_req;
  pctp_pkg::wr_req_t  wr_req;
  pctp_pkg::rd_rsp_t  rd_rsp;
  pctp_pkg::div_req_t div_req;
  pctp_pkg::div_rsp_t div_rsp;

  logic [pctp_pkg::SENSOR_W-1:0]     idx_r;
  logic [pctp_pkg::SENSOR_OUT_W-1:0] sensor_lo_r;
  logic [pctp_pkg::TIME_W-1:0]       ts_r;
  logic [pctp_pkg::COUNT_W-1:0]      cnt_r;
  logic [pctp_pkg::RATE_W-1:0]       rate_in_r;
  logic [pctp_pkg::TIME_W-1:0]       dt_r;
  logic [pctp_pkg::COUNT_W-1:0]      dc_r;
  logic [pctp_pkg::RATE_W-1:0]       rate_r;
  logic                              hit_r;
  logic [pctp_pkg::NUM_W-1:0]        num_r;
  logic [pctp_pkg::DEN_W-1:0]        den_r;

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [pctp_pkg::SENSOR_OUT_W-1:0] sensor_out_r;
  logic [pctp_pkg::TIME_W-1:0]       time_out_r;
  logic [pctp_pkg::WATTS_W-1:0]      power_r;

  logic                              in_range;
  logic                              out_free;
  logic                              den_ok;
  logic                              load_out;
  logic [pctp_pkg::RATE_W-1:0]       rate_used;
  logic [pctp_pkg::NUM_W-1:0]        num_prod;
  logic [pctp_pkg::DEN_W-1:0]        den_prod;

  // sensor table and divider
  pctp_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_req (rd_req),
    .wr_req (wr_req),
    .rd_rsp (rd_rsp)
  );

  pctp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // status terms
  assign in_range = (pctp_pkg::SENSOR_IN_W+1)'(in_ch.sensor) <
                    (pctp_pkg::SENSOR_IN_W+1)'(pctp_pkg::SENSORS);
  assign out_free = !out_valid_r || out_ch.ready;
  assign den_ok   = hit_r && (den_r != '0);

  // zero rate in the word keeps the stored one
  assign rate_used = (rate_in_r != '0) ? rate_in_r : rd_rsp.data.rate;

  // products
  assign num_prod = pctp_pkg::NUM_W'(dc_r) * pctp_pkg::NUM_W'(pctp_pkg::MS_PER_HOUR);
  assign den_prod = pctp_pkg::DEN_W'(dt_r) * pctp_pkg::DEN_W'(rate_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pctp_pkg::ST_IDLE: begin
        if (in_ch.valid && in_range) begin
          state_nxt = pctp_pkg::ST_CALC;
        end
      end
      pctp_pkg::ST_CALC:  state_nxt = pctp_pkg::ST_MUL;
      pctp_pkg::ST_MUL:   state_nxt = pctp_pkg::ST_CHECK;
      pctp_pkg::ST_CHECK: begin
        state_nxt = den_ok ? pctp_pkg::ST_DIV : pctp_pkg::ST_IDLE;
      end
      pctp_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = div_rsp.fit ? pctp_pkg::ST_OUT : pctp_pkg::ST_IDLE;
        end
      end
      pctp_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = pctp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pctp_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready    = (state_r == pctp_pkg::ST_IDLE);
    rd_req.en      = (state_r == pctp_pkg::ST_IDLE) && in_ch.valid && in_range;
    rd_req.addr    = in_ch.sensor[pctp_pkg::SENSOR_W-1:0];
    wr_req.en      = (state_r == pctp_pkg::ST_CALC);
    wr_req.addr    = idx_r;
    wr_req.data    = '{ts: ts_r, cnt: cnt_r, rate: rate_used};
    div_req.start  = (state_r == pctp_pkg::ST_CHECK) && den_ok;
    div_req.num    = num_r;
    div_req.den    = den_r;
    load_out       = (state_r == pctp_pkg::ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pctp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // reading capture, deltas and products
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      idx_r       <= in_ch.sensor[pctp_pkg::SENSOR_W-1:0];
      sensor_lo_r <= in_ch.sensor[pctp_pkg::SENSOR_OUT_W-1:0];
      ts_r        <= in_ch.timestamp;
      cnt_r       <= in_ch.pulse_count;
      rate_in_r   <= in_ch.pulses_per_unit;
    end
    if (state_r == pctp_pkg::ST_CALC) begin
      dt_r   <= pctp_pkg::abs_diff32(rd_rsp.data.ts, ts_r);
      dc_r   <= pctp_pkg::abs_diff32(rd_rsp.data.cnt, cnt_r);
      rate_r <= rate_used;
      hit_r  <= rd_rsp.seen;
    end
    if (state_r == pctp_pkg::ST_MUL) begin
      num_r <= num_prod;
      den_r <= den_prod;
    end
  end

  // output register
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sensor_out_r <= sensor_lo_r;
      time_out_r   <= ts_r;
      power_r      <= div_rsp.watts;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sensor_out  = sensor_out_r;
  assign out_ch.time_out    = time_out_r;
  assign out_ch.power_watts = power_r;

endmodule

`default_nettype wire

// ----- rtl/pctp_checker.sv -----
// ----------------------------------------------------------------------------
// pctp_checker: port-level checks of the pulse count to power core
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module pctp_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic [pctp_pkg::SENSOR_IN_W-1:0]  in_sensor,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [pctp_pkg::SENSOR_OUT_W-1:0] sensor_out,
  input wire logic [pctp_pkg::TIME_W-1:0]       time_out,
  input wire logic [pctp_pkg::WATTS_W-1:0]      power_watts
);

  logic in_accept;
  logic in_taken;
  assign in_accept = in_valid && in_ready;

  // accepted word with an index the table holds
  assign in_taken = in_accept &&
                    ((pctp_pkg::SENSOR_IN_W+1)'(in_sensor) <
                     (pctp_pkg::SENSOR_IN_W+1)'(pctp_pkg::SENSORS));

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sensor_out) &&
                                $stable(time_out) && $stable(power_watts))
    else $error("result word changed while stalled");

  // power never exceeds the limit
  a_power_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (power_watts <= pctp_pkg::WATTS_W'(10000)))
    else $error("power above limit");

  // one reading at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_taken |=> !in_ready)
    else $error("reading taken while another is in progress");

  // no result word appears right after a reading is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !$rose(out_valid))
    else $error("result word without processing time");

endmodule

bind pulse_count_to_power_core pctp_checker u_pctp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_sensor   (in_ch.sensor),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .sensor_out  (out_ch.sensor_out),
  .time_out    (out_ch.time_out),
  .power_watts (out_ch.power_watts)
);

`default_nettype wire

// ----- dv/pulse_count_to_power_core_tb.sv -----
// ----------------------------------------------------------------------------
// pulse_count_to_power_core_tb: self-checking bench of the pulse count core
// Drives directed readings, then random bursts, predicts the power word of each
// accepted reading from a per-sensor table of its own and checks every result
// word in order, field by field, while the result side stalls on its own
// pattern and once holds off long enough to back up the block.
// ----------------------------------------------------------------------------

module pulse_count_to_power_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 1450;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT_ITEM  = 600;
  localparam int DRAIN_CYCLES  = 64;

  typedef struct packed {
    logic [pctp_pkg::SENSOR_IN_W-1:0] sensor;
    logic [pctp_pkg::TIME_W-1:0]      timestamp;
    logic [pctp_pkg::COUNT_W-1:0]     pulse_count;
    logic [pctp_pkg::RATE_W-1:0]      pulses_per_unit;
  } reading_t;

  typedef struct packed {
    logic [pctp_pkg::SENSOR_OUT_W-1:0] sensor_out;
    logic [pctp_pkg::TIME_W-1:0]       time_out;
    logic [pctp_pkg::WATTS_W-1:0]      power_watts;
  } power_t;

  // result side stall patterns
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_COMB,
    RX_SLOW
  } rx_mode_t;

  // per-sensor power predictor and queue of expected words
  class power_scoreboard;
    bit                           seen      [pctp_pkg::SENSORS];
    logic [pctp_pkg::TIME_W-1:0]  last_time [pctp_pkg::SENSORS];
    logic [pctp_pkg::COUNT_W-1:0] last_count[pctp_pkg::SENSORS];
    logic [pctp_pkg::RATE_W-1:0]  last_rate [pctp_pkg::SENSORS];
    power_t                       expected_power[$];
    int                           errors;

    function new();
      for (int i = 0; i < pctp_pkg::SENSORS; i++) begin
        seen[i]       = 1'b0;
        last_time[i]  = '0;
        last_count[i] = '0;
        last_rate[i]  = '0;
      end
      errors = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function int pending();
      return expected_power.size();
    endfunction

    // update the table for one accepted reading, queue its power if any
    function void note_reading(reading_t r);
      int unsigned                  idx;
      logic [pctp_pkg::RATE_W-1:0]  rate_used;
      logic [pctp_pkg::TIME_W-1:0]  dt32;
      logic [pctp_pkg::COUNT_W-1:0] dc32;
      logic [63:0]                  num;
      logic [63:0]                  den;
      logic [63:0]                  watts;
      power_t                       p;
      if (r.sensor >= pctp_pkg::SENSORS) return;
      idx = r.sensor;
      rate_used = (r.pulses_per_unit != '0) ? r.pulses_per_unit : last_rate[idx];
      last_rate[idx] = rate_used;
      if (seen[idx]) begin
        dt32 = (last_time[idx] >= r.timestamp) ? last_time[idx] - r.timestamp
                                               : r.timestamp - last_time[idx];
        dc32 = (last_count[idx] >= r.pulse_count) ? last_count[idx] - r.pulse_count
                                                  : r.pulse_count - last_count[idx];
        num = {32'd0, dc32} * {42'd0, pctp_pkg::MS_PER_HOUR};
        den = {32'd0, dt32} * {48'd0, rate_used};
        if (den != 64'd0 && num <= {49'd0, pctp_pkg::MAX_WATTS} * den) begin
          watts = num / den;
          p.sensor_out  = r.sensor[pctp_pkg::SENSOR_OUT_W-1:0];
          p.time_out    = r.timestamp;
          p.power_watts = watts[pctp_pkg::WATTS_W-1:0];
          expected_power.push_back(p);
        end
      end
      seen[idx]       = 1'b1;
      last_time[idx]  = r.timestamp;
      last_count[idx] = r.pulse_count;
    endfunction

    // compare one result word with the oldest expectation
    task check_power(power_t got);
      power_t exp_p;
      if (expected_power.size() == 0) begin
        report_mismatch($sformatf("unexpected word sensor %0d time %0d watts %0d",
                                  got.sensor_out, got.time_out, got.power_watts));
        return;
      end
      exp_p = expected_power.pop_front();
      if (got.sensor_out != exp_p.sensor_out)
        report_mismatch($sformatf("sensor_out %0d, expected %0d",
                                  got.sensor_out, exp_p.sensor_out));
      if (got.time_out != exp_p.time_out)
        report_mismatch($sformatf("time_out %0d, expected %0d",
                                  got.time_out, exp_p.time_out));
      if (got.power_watts != exp_p.power_watts)
        report_mismatch($sformatf("power_watts %0d, expected %0d (sensor %0d time %0d)",
                                  got.power_watts, exp_p.power_watts,
                                  exp_p.sensor_out, exp_p.time_out));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic hold_req;
  int   cycle_cnt;

  pctp_in_if  in_if ();
  pctp_out_if out_if ();

  power_scoreboard sb = new();

  // stimulus-side view of each sensor, used to build well-formed readings
  bit [pctp_pkg::TIME_W-1:0]  stim_time [pctp_pkg::SENSORS];
  bit [pctp_pkg::COUNT_W-1:0] stim_count[pctp_pkg::SENSORS];
  bit [pctp_pkg::RATE_W-1:0]  stim_rate [pctp_pkg::SENSORS];

  pulse_count_to_power_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // offer one word and wait until it is taken
  task drive_word(reading_t r);
    in_if.valid           <= 1'b1;
    in_if.sensor          <= r.sensor;
    in_if.timestamp       <= r.timestamp;
    in_if.pulse_count     <= r.pulse_count;
    in_if.pulses_per_unit <= r.pulses_per_unit;
    do @(posedge clk); while (!in_if.ready);
    sb.note_reading(r);
    if (r.sensor < pctp_pkg::SENSORS) begin
      stim_time[r.sensor]  = r.timestamp;
      stim_count[r.sensor] = r.pulse_count;
      if (r.pulses_per_unit != '0) stim_rate[r.sensor] = r.pulses_per_unit;
    end
  endtask

  task idle_cycles(int n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function reading_t mk(logic [7:0] s, logic [31:0] ts, logic [31:0] cnt,
                        logic [15:0] rate);
    reading_t r;
    r.sensor          = s;
    r.timestamp       = ts;
    r.pulse_count     = cnt;
    r.pulses_per_unit = rate;
    return r;
  endfunction

  // plausible reading: time usually moves on, count moves by a realistic power
  function reading_t gen_metered();
    int unsigned  idx;
    int unsigned  dt;
    int unsigned  watts;
    int unsigned  pick;
    bit [63:0]    dc;
    bit [15:0]    field_rate;
    bit [15:0]    eff_rate;
    reading_t     r;
    idx  = $urandom_range(0, pctp_pkg::SENSORS - 1);
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      field_rate = '0;
    end else if (pick == 1) begin
      case ($urandom_range(0, 4))
        0: field_rate = 16'd1000;
        1: field_rate = 16'd800;
        2: field_rate = 16'd3200;
        3: field_rate = 16'd1;
        default: field_rate = 16'($urandom_range(1, 65535));
      endcase
    end else begin
      field_rate = (stim_rate[idx] != '0) ? stim_rate[idx] : 16'd1000;
    end
    eff_rate = (field_rate != '0) ? field_rate : stim_rate[idx];
    dt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(60, 7200);
    watts = $urandom_range(0, 10500);
    dc = ({32'd0, watts} * {32'd0, dt} * {48'd0, eff_rate}) / 64'd3600000;
    r.sensor          = 8'(idx);
    r.pulses_per_unit = field_rate;
    r.timestamp       = ($urandom_range(0, 31) == 0) ? stim_time[idx] - dt
                                                     : stim_time[idx] + dt;
    r.pulse_count     = ($urandom_range(0, 15) == 0) ? stim_count[idx] - dc[31:0]
                                                     : stim_count[idx] + dc[31:0];
    return r;
  endfunction

  // broken or odd readings
  function reading_t gen_noise();
    reading_t r;
    r.sensor          = 8'($urandom);
    r.timestamp       = $urandom;
    r.pulse_count     = $urandom;
    r.pulses_per_unit = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        // same timestamp as last time, zero time delta
        r.sensor    = 8'($urandom_range(0, pctp_pkg::SENSORS - 1));
        r.timestamp = stim_time[r.sensor];
        r.pulse_count = stim_count[r.sensor] + 32'($urandom_range(0, 50));
      end
      2: r.sensor = 8'($urandom_range(pctp_pkg::SENSORS, 255));
      default: r.sensor = 8'($urandom_range(0, pctp_pkg::SENSORS - 1));
    endcase
    return r;
  endfunction

  // result side: check words, stall on a pattern, one long hold-off
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    int       hold_left;
    bit       hold_done;
    power_t   got;
    mode      = RX_OPEN;
    mode_left = 0;
    phase     = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got.sensor_out  = out_if.sensor_out;
        got.time_out    = out_if.time_out;
        got.power_watts = out_if.power_watts;
        sb.check_power(got);
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_OPEN: out_if.ready <= 1'b1;
          RX_COIN: out_if.ready <= 1'($urandom);
          RX_COMB: out_if.ready <= (phase % 5) != 0;
          default: out_if.ready <= (phase % 16) < 4;
        endcase
      end
    end
  end

  // reset, directed readings, random bursts, drain
  initial begin
    int       counted;
    int       burst_left;
    reading_t r;
    counted    = 0;
    burst_left = 0;
    rst_n    <= 1'b0;
    hold_req <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.sensor          <= '0;
    in_if.timestamp       <= '0;
    in_if.pulse_count     <= '0;
    in_if.pulses_per_unit <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // first reading, stored rate reuse, ignored indexes
    drive_word(mk(8'd0, 32'd1000, 32'd500, 16'd1000));
    drive_word(mk(8'd0, 32'd1060, 32'd517, 16'd0));
    drive_word(mk(8'd16, 32'd5, 32'd5, 16'd5));
    drive_word(mk(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    idle_cycles(3);
    // zero time delta, then both deltas running backwards
    drive_word(mk(8'd0, 32'd1060, 32'd600, 16'd0));
    drive_word(mk(8'd0, 32'd1000, 32'd500, 16'd0));
    // zero stored rate gives a zero denominator
    drive_word(mk(8'd1, 32'd0, 32'd0, 16'd0));
    drive_word(mk(8'd1, 32'd10, 32'd5, 16'd0));
    // exactly the power limit, then just above it
    drive_word(mk(8'd1, 32'd11, 32'd6, 16'd360));
    drive_word(mk(8'd1, 32'd12, 32'd7, 16'd359));
    // no pulses, zero watts
    drive_word(mk(8'd1, 32'd13, 32'd7, 16'd0));
    idle_cycles(1);
    // full-scale deltas and rate
    drive_word(mk(8'd2, 32'd0, 32'd0, 16'hFFFF));
    drive_word(mk(8'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0));
    // top sensor index, far out of range then zero watts
    drive_word(mk(8'd15, 32'hFFFF_FFFF, 32'd0, 16'd1));
    drive_word(mk(8'd15, 32'd0, 32'hFFFF_FFFF, 16'd1));
    drive_word(mk(8'd15, 32'd3600, 32'hFFFF_FFFF, 16'hFFFF));
    drive_word(mk(8'd3, 32'd100, 32'd0, 16'd1));
    drive_word(mk(8'd3, 32'd3700, 32'd10, 16'd0));

    // random bursts, mostly well-formed readings
    while (counted < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(0, 6));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 20);
      end
      burst_left--;
      r = ($urandom_range(0, 5) == 0) ? gen_noise() : gen_metered();
      counted++;
      if (counted == HOLD_AT_ITEM) hold_req <= 1'b1;
      drive_word(r);
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
